// ----- hw/rtl/afb_pkg.sv -----
package afb_pkg;

  // Queue between the classifier and the byte sequencer
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] MAX_PAYLOAD = 8'd240;

  // Frame bytes
  localparam logic [7:0] START_DELIM = 8'h7E;
  localparam logic [7:0] TX64_API_ID = 8'h00;
  localparam logic [7:0] TX_FRAME_ID = 8'h00;
  localparam logic [7:0] TX_OPTION   = 8'h01;
  localparam logic [7:0] AT_API_ID   = 8'h08;
  localparam logic [7:0] AT_BYTE     = 8'h42;
  localparam logic [7:0] CSUM_BASE   = 8'hFF;
  localparam logic [7:0] ERR_BYTE    = 8'h00;

  // Header lengths in bytes, counted from the API id
  localparam logic [3:0] TX_HDR_LEN = 4'd12;
  localparam logic [3:0] AT_HDR_LEN = 4'd2;
  // Delimiter plus two length bytes
  localparam logic [3:0] PRE_LEN    = 4'd3;

  // Input opcodes
  localparam logic OPC_START   = 1'b0;
  localparam logic OPC_PAYLOAD = 1'b1;

  // Frame kinds
  localparam logic KIND_TX64 = 1'b0;
  localparam logic KIND_AT   = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_HI    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_LO    = 2'd2;

  typedef enum logic [1:0] {
    OP_START,
    OP_PAYLOAD,
    OP_ERROR
  } afb_op_e;

  // One classified item as held in the queue
  typedef struct packed {
    afb_op_e    op;
    logic [7:0] data;   // command byte on start, payload byte otherwise
    logic [7:0] count;  // saturated payload count on start
    logic       last;   // payload byte closes the frame
  } afb_cmd_t;

  typedef struct packed {
    logic        frame_kind;
    logic [31:0] addr_hi;
    logic [31:0] addr_lo;
  } afb_cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       sequence_error;
  } afb_res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } afb_qstat_t;

  function automatic logic [3:0] hdr_len(input logic kind);
    return (kind == KIND_AT) ? AT_HDR_LEN : TX_HDR_LEN;
  endfunction

  // Header byte at position idx, counted from the API id
  function automatic logic [7:0] hdr_byte(input afb_cfg_t cfg, input logic [3:0] idx,
                                          input logic [7:0] cmd);
    logic [7:0] b;
    b = ERR_BYTE;
    if (cfg.frame_kind == KIND_AT) begin
      b = (idx == 4'd0) ? AT_API_ID : AT_BYTE;
    end else begin
      case (idx)
        4'd0:    b = TX64_API_ID;
        4'd1:    b = TX_FRAME_ID;
        4'd2:    b = cfg.addr_hi[31:24];
        4'd3:    b = cfg.addr_hi[23:16];
        4'd4:    b = cfg.addr_hi[15:8];
        4'd5:    b = cfg.addr_hi[7:0];
        4'd6:    b = cfg.addr_lo[31:24];
        4'd7:    b = cfg.addr_lo[23:16];
        4'd8:    b = cfg.addr_lo[15:8];
        4'd9:    b = cfg.addr_lo[7:0];
        4'd10:   b = TX_OPTION;
        4'd11:   b = cmd;
        default: b = ERR_BYTE;
      endcase
    end
    return b;
  endfunction

endpackage

// ----- hw/rtl/afb_front.sv -----
module afb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             opcode_i,
  input  logic [7:0]       command_type_i,
  input  logic [7:0]       payload_count_i,
  input  logic [7:0]       payload_byte_i,
  input  afb_pkg::afb_qstat_t q_stat_i,
  output logic             q_push_o,
  output afb_pkg::afb_cmd_t q_cmd_o
);
  import afb_pkg::*;

  logic       open_q, open_d;
  logic [7:0] left_q, left_d;
  logic [7:0] count_sat;

  assign in_ready_o = !q_stat_i.full;
  assign q_push_o   = in_valid_i && !q_stat_i.full;
  assign count_sat  = (payload_count_i > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_count_i;

  // Classify the item and track the open frame
  always_comb begin
    open_d        = open_q;
    left_d        = left_q;
    q_cmd_o.op    = OP_ERROR;
    q_cmd_o.data  = payload_byte_i;
    q_cmd_o.count = count_sat;
    q_cmd_o.last  = 1'b0;
    if (opcode_i == OPC_START) begin
      q_cmd_o.op   = OP_START;
      q_cmd_o.data = command_type_i;
      open_d       = (count_sat != 8'd0);
      left_d       = count_sat;
    end else if (open_q) begin
      q_cmd_o.op   = OP_PAYLOAD;
      q_cmd_o.last = (left_q == 8'd1);
      left_d       = left_q - 8'd1;
      open_d       = (left_q != 8'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= 8'd0;
    end else if (q_push_o) begin
      open_q <= open_d;
      left_q <= left_d;
    end
  end

endmodule

// ----- hw/rtl/afb_queue.sv -----
module afb_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  afb_pkg::afb_cmd_t   cmd_i,
  input  logic                pop_i,
  output afb_pkg::afb_cmd_t   cmd_o,
  output afb_pkg::afb_qstat_t stat_o
);
  import afb_pkg::*;

  afb_cmd_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q;

  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign cmd_o        = mem_q[rd_q];

  // Store the item at the write pointer
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/afb_back.sv -----
module afb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  afb_pkg::afb_cfg_t   cfg_i,
  input  afb_pkg::afb_cmd_t   cmd_i,
  input  afb_pkg::afb_qstat_t q_stat_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output afb_pkg::afb_res_t   out_o
);
  import afb_pkg::*;

  logic [3:0]  step_q, step_d;
  logic [7:0]  sum_q, sum_d;
  logic        vld_q;
  afb_res_t    res_q, res_d;
  logic        emit;
  logic        final_step;
  logic [3:0]  hlen;
  logic [3:0]  hidx;
  logic [3:0]  hdr_end;
  logic [15:0] flen;
  logic [7:0]  hbyte;

  assign emit    = !q_stat_i.empty && (!vld_q || out_ready_i);
  assign q_pop_o = emit && final_step;
  assign hlen    = hdr_len(cfg_i.frame_kind);
  assign hidx    = step_q - PRE_LEN;
  assign hdr_end = PRE_LEN + hlen;
  assign flen    = 16'(hlen) + 16'(cmd_i.count);
  assign hbyte   = hdr_byte(cfg_i, hidx, cmd_i.data);

  // Produce the byte for the current step of the head item
  always_comb begin
    res_d      = '0;
    sum_d      = sum_q;
    final_step = 1'b1;
    case (cmd_i.op)
      OP_START: begin
        final_step = 1'b0;
        if (step_q == 4'd0) begin
          res_d.out_byte = START_DELIM;
          sum_d          = 8'd0;
        end else if (step_q == 4'd1) begin
          res_d.out_byte = flen[15:8];
        end else if (step_q == 4'd2) begin
          res_d.out_byte = flen[7:0];
        end else if (step_q < hdr_end) begin
          res_d.out_byte = hbyte;
          sum_d          = sum_q + hbyte;
          final_step     = (step_q == hdr_end - 4'd1) && (cmd_i.count != 8'd0);
        end else begin
          // empty payload: checksum right after the header
          res_d.out_byte  = CSUM_BASE - sum_q;
          res_d.last_byte = 1'b1;
          sum_d           = 8'd0;
          final_step      = 1'b1;
        end
      end
      OP_PAYLOAD: begin
        if (step_q == 4'd0) begin
          res_d.out_byte = cmd_i.data;
          sum_d          = sum_q + cmd_i.data;
          final_step     = !cmd_i.last;
        end else begin
          res_d.out_byte  = CSUM_BASE - sum_q;
          res_d.last_byte = 1'b1;
          sum_d           = 8'd0;
        end
      end
      default: begin
        res_d.out_byte       = ERR_BYTE;
        res_d.last_byte      = 1'b1;
        res_d.sequence_error = 1'b1;
      end
    endcase
    step_d = final_step ? 4'd0 : step_q + 4'd1;
  end

  // Step counter and checksum accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 4'd0;
      sum_q  <= 8'd0;
      vld_q  <= 1'b0;
    end else begin
      if (emit) begin
        step_q <= step_d;
        sum_q  <= sum_d;
        vld_q  <= 1'b1;
      end else if (out_ready_i) begin
        vld_q  <= 1'b0;
      end
    end
  end

  // Output register: load on emit, hold while stalled
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_o       = res_q;

endmodule

// ----- hw/rtl/api_frame_builder_core.sv -----
// API frame builder. Input items carry a start (tuser 0: command byte and payload
// count) or one payload byte (tuser 1); the block sends the frame byte by byte on
// the output stream, one byte per cycle when the sink is ready and the queue is not
// empty, with tlast on the checksum and on an error result. A start gives 3 +
// header (2 or 12) bytes, plus the checksum when the payload count is zero; a
// payload byte gives one byte, or two on the last payload byte. The output byte
// sequencer sets the rate; input is taken every cycle while the four-entry queue
// in front of it has room. Configuration is sampled by the sequencer and must
// only be written while the block is idle.
module api_frame_builder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // command_type[7:0], payload_count[15:8], payload_byte[23:16]
  input  logic        s_axis_tuser,   // opcode
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic        m_axis_tlast,   // last_byte
  output logic        m_axis_tuser    // sequence_error
);
  import afb_pkg::*;

  afb_cfg_t   cfg_q;
  afb_cmd_t   push_cmd, head_cmd;
  afb_qstat_t q_stat;
  afb_res_t   res;
  logic       q_push, q_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_KIND: cfg_q.frame_kind <= cfg_data_i[0];
        CFG_ADDR_HI:    cfg_q.addr_hi    <= cfg_data_i;
        CFG_ADDR_LO:    cfg_q.addr_lo    <= cfg_data_i;
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  afb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .opcode_i        (s_axis_tuser),
    .command_type_i  (s_axis_tdata[7:0]),
    .payload_count_i (s_axis_tdata[15:8]),
    .payload_byte_i  (s_axis_tdata[23:16]),
    .q_stat_i        (q_stat),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  afb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .pop_i  (q_pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  afb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (head_cmd),
    .q_stat_i    (q_stat),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = res.out_byte;
  assign m_axis_tlast = res.last_byte;
  assign m_axis_tuser = res.sequence_error;

  // Never write into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_stat.full))
    else $error("queue push while full");

  // Never retire an item from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  // A retired item leaves its final byte in the output register
  a_pop_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> m_axis_tvalid)
    else $error("retired item left no result");

  // An error result is a single zero byte that ends its run
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 8'h00))
    else $error("malformed error result");

endmodule
